FILE: rtl/core/sctc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller package
// Shared widths, request and mode codes, channel payloads and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package sctc_pkg;

  // Widths of time values, counters and configuration words.
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned CFG_W      = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  // Serial divider step count and counter width.
  localparam int unsigned DIV_STEPS = TIME_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] MAX_TICK_RST   = CFG_W'(10000);
  localparam logic [CFG_W-1:0] DEBUG_TICK_RST = CFG_W'(10000);

  // Request kinds. Code 7 is unused and only reports the mode.
  typedef enum logic [2:0] {
    REQ_TICK        = 3'd0,
    REQ_START       = 3'd1,
    REQ_TO_REALTIME = 3'd2,
    REQ_TO_DEBUG    = 3'd3,
    REQ_TERMINATE   = 3'd4,
    REQ_GRANT       = 3'd5,
    REQ_EXPORT      = 3'd6
  } req_type_e;

  // Clock modes.
  typedef enum logic [1:0] {
    MODE_REALTIME   = 2'd0,
    MODE_DEBUG      = 2'd1,
    MODE_TERMINATED = 2'd2
  } mode_e;

  // Configuration register indexes, taken from paddr[2].
  typedef enum logic {
    REG_MAX_TICK   = 1'b0,
    REG_DEBUG_TICK = 1'b1
  } reg_idx_e;

  // Request payload.
  typedef struct packed {
    logic [2:0]        req_type;
    logic [TIME_W-1:0] now_us;
    logic              cold_start;
    logic [CNT_W-1:0]  tick_count;
  } req_t;

  // Result payload.
  typedef struct packed {
    logic [CFG_W-1:0]  interval_us;
    logic              ok;
    logic [1:0]        mode;
    logic [TIME_W-1:0] total_ticks;
    logic [TIME_W-1:0] ingame_us;
    logic [TIME_W-1:0] realtime_us;
    logic [TIME_W-1:0] deviation_us;
    logic [TIME_W-1:0] avg_tick_us;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic exec;
    logic div_start;
    logic tick_s1;
    logic tick_s2;
    logic tick_s3;
    logic tick_s4;
    logic tick_s5;
    logic avg_load;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic       terminated;
    logic       div_needed;
    logic       div_done;
  } ctrl_sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/sctc_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller channels
// Valid/ready channels for requests and for results.
// ----------------------------------------------------------------------------
interface sctc_req_if import sctc_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sctc_rsp_if import sctc_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/sim_clock_tick_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller
// Keeps a simulated clock in real-time, debug or terminated mode.
// ----------------------------------------------------------------------------
// Requests arrive on req_i and each produces exactly one result on rsp_o; both
// channels transfer when valid and ready are high at a rising clock edge.
// max_tick_us (address 0) and debug_tick_us (address 4) are written through
// the APB port, which never waits.
// One request is processed at a time. A result is loaded into the output
// register after decode for mode changes, grants, start, terminate, unused
// codes, ticks in terminated mode and exports with no ticks in the period;
// after five tick steps for a tick; and, for an export that needs the
// average, after the 48-step serial divider. req_i is ready again in the
// cycle after the result is loaded.
// While the receiver stalls, the output register holds its result and the
// block still takes and processes one more request, which then waits until
// the output register frees.
// Reset returns the clock to real-time mode with all counters at zero and the
// configuration registers at 10000.
// ----------------------------------------------------------------------------
module sim_clock_tick_controller import sctc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  sctc_req_if.sink                   req_i,
  sctc_rsp_if.source                 rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0]      prdata,
  output logic                       pready
);

  logic [CFG_W-1:0] max_tick_q, max_tick_d;
  logic [CFG_W-1:0] debug_tick_q, debug_tick_d;
  logic             cfg_wr;
  ctrl_cmd_t        cmd;
  ctrl_sts_t        sts;

  // Configuration register writes in the APB access phase.
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    max_tick_d   = max_tick_q;
    debug_tick_d = debug_tick_q;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_MAX_TICK:   max_tick_d   = pwdata[CFG_W-1:0];
        REG_DEBUG_TICK: debug_tick_d = pwdata[CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_tick_q   <= MAX_TICK_RST;
      debug_tick_q <= DEBUG_TICK_RST;
    end else begin
      max_tick_q   <= max_tick_d;
      debug_tick_q <= debug_tick_d;
    end
  end

  // Register read-back.
  always_comb begin
    unique case (paddr[2])
      REG_MAX_TICK:   prdata = APB_DATA_W'(max_tick_q);
      REG_DEBUG_TICK: prdata = APB_DATA_W'(debug_tick_q);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  sctc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sctc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_i        (req_i.payload),
    .max_tick_i   (max_tick_q),
    .debug_tick_i (debug_tick_q),
    .sts_o        (sts),
    .rsp_o        (rsp_o.payload)
  );

endmodule
`default_nettype wire

FILE: rtl/core/sctc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sctc_div import sctc_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [TIME_W-1:0] dividend_i,
  input  wire logic [TIME_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [TIME_W-1:0]      quotient_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [TIME_W-1:0]    rem_q, rem_d;
  logic [TIME_W-1:0]    quo_q, quo_d;
  logic [TIME_W-1:0]    dvs_q, dvs_d;
  logic [TIME_W:0]      rem_sh;
  logic [TIME_W+1:0]    trial;

  // Shift the next dividend bit into the remainder and try the subtraction.
  assign rem_sh = {rem_q, quo_q[TIME_W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_STEPS);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[TIME_W+1]) begin
        rem_d = rem_sh[TIME_W-1:0];
        quo_d = {quo_q[TIME_W-2:0], 1'b0};
      end else begin
        rem_d = trial[TIME_W-1:0];
        quo_d = {quo_q[TIME_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: rtl/core/sctc_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller datapath
// Clock state, tick arithmetic in five steps, statistics and result registers.
// ----------------------------------------------------------------------------
module sctc_dp import sctc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ctrl_cmd_t        cmd_i,
  input  wire req_t             req_i,
  input  wire logic [CFG_W-1:0] max_tick_i,
  input  wire logic [CFG_W-1:0] debug_tick_i,
  output ctrl_sts_t             sts_o,
  output rsp_t                  rsp_o
);

  // Clock state.
  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] started_q, started_d;
  logic [TIME_W-1:0] game_q, game_d;
  logic [TIME_W-1:0] slip_q, slip_d;
  logic [CNT_W-1:0]  ticks_left_q, ticks_left_d;
  logic [TIME_W-1:0] tick_total_q, tick_total_d;
  logic [TIME_W-1:0] period_ticks_q, period_ticks_d;
  logic [TIME_W-1:0] period_time_q, period_time_d;

  // Request and tick working registers.
  req_t              req_q, req_d;
  logic [TIME_W-1:0] elapsed_q, elapsed_d;
  logic [TIME_W-1:0] expect_q, expect_d;
  logic [TIME_W-1:0] lag_q, lag_d;
  logic [TIME_W-1:0] excess_q, excess_d;
  logic [TIME_W-1:0] sum_q, sum_d;
  logic [CFG_W-1:0]  dt_q, dt_d;
  logic [CFG_W-1:0]  sub_q, sub_d;
  rsp_t              pend_q, pend_d;
  rsp_t              out_q, out_d;

  logic [TIME_W:0]   lag_diff;
  logic [TIME_W:0]   over_diff;
  logic [TIME_W:0]   sat_diff;
  logic              div_done;
  logic [TIME_W-1:0] div_quo;

  // Borrow of each subtraction doubles as the compare.
  assign lag_diff  = {1'b0, elapsed_q} - {1'b0, expect_q};
  assign over_diff = {1'b0, lag_q} - {1'b0, TIME_W'(max_tick_i)};
  assign sat_diff  = {1'b0, sum_q} - {1'b0, TIME_W'(sub_q)};

  sctc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (period_time_q),
    .divisor_i  (period_ticks_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    mode_d         = mode_q;
    started_d      = started_q;
    game_d         = game_q;
    slip_d         = slip_q;
    ticks_left_d   = ticks_left_q;
    tick_total_d   = tick_total_q;
    period_ticks_d = period_ticks_q;
    period_time_d  = period_time_q;
    req_d          = req_q;
    elapsed_d      = elapsed_q;
    expect_d       = expect_q;
    lag_d          = lag_q;
    excess_d       = excess_q;
    sum_d          = sum_q;
    dt_d           = dt_q;
    sub_d          = sub_q;
    pend_d         = pend_q;
    out_d          = out_q;

    // Capture the accepted request.
    if (cmd_i.load_req) begin
      req_d = req_i;
    end

    // Mode changes, grants, start and the statistics snapshot.
    if (cmd_i.exec) begin
      pend_d = '0;
      unique case (req_q.req_type)
        REQ_START: begin
          if (req_q.cold_start) begin
            mode_d = MODE_DEBUG;
          end
          started_d = req_q.now_us;
          game_d    = '0;
          slip_d    = '0;
        end
        REQ_TO_REALTIME: begin
          if (mode_q == MODE_REALTIME) begin
            pend_d.ok = 1'b1;
          end else if (mode_q == MODE_DEBUG && ticks_left_q == '0) begin
            mode_d    = MODE_REALTIME;
            pend_d.ok = 1'b1;
          end
        end
        REQ_TO_DEBUG: begin
          if (mode_q == MODE_REALTIME || mode_q == MODE_DEBUG) begin
            mode_d    = MODE_DEBUG;
            pend_d.ok = 1'b1;
          end
        end
        REQ_TERMINATE: begin
          mode_d = MODE_TERMINATED;
        end
        REQ_GRANT: begin
          if (mode_q == MODE_DEBUG && ticks_left_q == '0) begin
            ticks_left_d = req_q.tick_count;
            pend_d.ok    = 1'b1;
          end
        end
        REQ_EXPORT: begin
          pend_d.total_ticks  = tick_total_q;
          pend_d.ingame_us    = game_q;
          pend_d.realtime_us  = req_q.now_us - started_q;
          pend_d.deviation_us = slip_q;
          period_ticks_d      = '0;
          period_time_d       = '0;
        end
        default: begin
        end
      endcase
      pend_d.mode = mode_d;
    end

    // Tick step 1: elapsed real time and expected time.
    if (cmd_i.tick_s1) begin
      elapsed_d = req_q.now_us - started_q;
      expect_d  = game_q + slip_q;
    end

    // Tick step 2: lag, with real time behind expected time read as no lag.
    if (cmd_i.tick_s2) begin
      lag_d = lag_diff[TIME_W] ? '0 : lag_diff[TIME_W-1:0];
    end

    // Tick step 3: interval to issue and slip to book.
    if (cmd_i.tick_s3) begin
      if (mode_q == MODE_REALTIME) begin
        if (!over_diff[TIME_W] && over_diff[TIME_W-1:0] != '0) begin
          excess_d = over_diff[TIME_W-1:0];
          dt_d     = max_tick_i;
        end else begin
          excess_d = '0;
          dt_d     = lag_q[CFG_W-1:0];
        end
        sub_d          = '0;
        tick_total_d   = tick_total_q + TIME_W'(1);
        period_ticks_d = period_ticks_q + TIME_W'(1);
      end else begin
        excess_d = lag_q;
        if (ticks_left_q != '0) begin
          dt_d           = debug_tick_i;
          ticks_left_d   = ticks_left_q - CNT_W'(1);
          tick_total_d   = tick_total_q + TIME_W'(1);
          period_ticks_d = period_ticks_q + TIME_W'(1);
        end else begin
          dt_d = '0;
        end
        sub_d = dt_d;
      end
    end

    // Tick step 4: advance in-game time and add the slip.
    if (cmd_i.tick_s4) begin
      sum_d              = slip_q + excess_q;
      game_d             = game_q + TIME_W'(dt_q);
      period_time_d      = period_time_q + TIME_W'(dt_q);
      pend_d.interval_us = dt_q;
    end

    // Tick step 5: store the new slip; in debug mode the issued interval comes
    // off it, and it saturates at zero.
    if (cmd_i.tick_s5) begin
      slip_d = sat_diff[TIME_W] ? '0 : sat_diff[TIME_W-1:0];
    end

    // Average tick length from the divider.
    if (cmd_i.avg_load) begin
      pend_d.avg_tick_us = div_quo;
    end

    // Move the finished result to the output register.
    if (cmd_i.out_load) begin
      out_d = pend_q;
    end
  end

  // Clock state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= MODE_REALTIME;
      started_q      <= '0;
      game_q         <= '0;
      slip_q         <= '0;
      ticks_left_q   <= '0;
      tick_total_q   <= '0;
      period_ticks_q <= '0;
      period_time_q  <= '0;
    end else begin
      mode_q         <= mode_d;
      started_q      <= started_d;
      game_q         <= game_d;
      slip_q         <= slip_d;
      ticks_left_q   <= ticks_left_d;
      tick_total_q   <= tick_total_d;
      period_ticks_q <= period_ticks_d;
      period_time_q  <= period_time_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    elapsed_q <= elapsed_d;
    expect_q  <= expect_d;
    lag_q     <= lag_d;
    excess_q  <= excess_d;
    sum_q     <= sum_d;
    dt_q      <= dt_d;
    sub_q     <= sub_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign sts_o.req_type   = req_q.req_type;
  assign sts_o.terminated = (mode_q == MODE_TERMINATED);
  assign sts_o.div_needed = (period_ticks_q != '0);
  assign sts_o.div_done   = div_done;
  assign rsp_o            = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/sctc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller sequencer
// Walks each request through decode, tick steps or division, and hands the
// result to the output register.
// ----------------------------------------------------------------------------
module sctc_ctrl import sctc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_T1     = 4'd2;
  localparam logic [3:0] S_T2     = 4'd3;
  localparam logic [3:0] S_T3     = 4'd4;
  localparam logic [3:0] S_T4     = 4'd5;
  localparam logic [3:0] S_T5     = 4'd6;
  localparam logic [3:0] S_DIV    = 4'd7;
  localparam logic [3:0] S_PEND   = 4'd8;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd_o.exec = 1'b1;
        if (sts_i.req_type == REQ_TICK && !sts_i.terminated) begin
          state_d = S_T1;
        end else if (sts_i.req_type == REQ_EXPORT && sts_i.div_needed) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_PEND;
        end
      end
      S_T1: begin
        cmd_o.tick_s1 = 1'b1;
        state_d       = S_T2;
      end
      S_T2: begin
        cmd_o.tick_s2 = 1'b1;
        state_d       = S_T3;
      end
      S_T3: begin
        cmd_o.tick_s3 = 1'b1;
        state_d       = S_T4;
      end
      S_T4: begin
        cmd_o.tick_s4 = 1'b1;
        state_d       = S_T5;
      end
      S_T5: begin
        cmd_o.tick_s5 = 1'b1;
        state_d       = S_PEND;
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.avg_load = 1'b1;
          state_d        = S_PEND;
        end
      end
      S_PEND: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: rtl/core/sctc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module sctc_checker import sctc_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_i,
  input wire logic rsp_valid_i,
  input wire logic rsp_ready_i,
  input wire rsp_t rsp_i
);

  logic stats_zero;

  assign stats_zero = (rsp_i.total_ticks == '0) && (rsp_i.ingame_us == '0) &&
                      (rsp_i.realtime_us == '0) && (rsp_i.deviation_us == '0) &&
                      (rsp_i.avg_tick_us == '0);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result withdrawn while stalled");

  // Only one request is in flight: the cycle after a transfer is not ready.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while another is in flight");

  // An accepted mode switch or grant carries no interval and no statistics.
  a_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.ok |-> rsp_i.interval_us == '0 && stats_zero)
    else $error("accepted switch or grant carries tick or statistics data");

  // A tick result with an interval carries no acceptance flag or statistics.
  a_tick_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_i.interval_us != '0 |-> !rsp_i.ok && stats_zero)
    else $error("tick result carries switch or statistics data");

endmodule

bind sim_clock_tick_controller sctc_checker u_sctc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .rsp_i       (rsp_o.payload)
);
`default_nettype wire

FILE: tb/sim_clock_tick_controller_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Simulation clock tick controller testbench
// Drives requests with random gaps, stalls the result channel in bursts and
// compares every result against an in-bench model of the clock. Runs a short
// directed sequence, then random phases under several register settings.
// ----------------------------------------------------------------------------
module sim_clock_tick_controller_tb;
  import sctc_pkg::*;

  localparam logic [2:0] REQ_UNUSED = 3'd7;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Keeps a model of the clock and the queue of results it still owes.
  class tick_ledger;
    logic [CFG_W-1:0]  max_tick;
    logic [CFG_W-1:0]  debug_tick;
    mode_e             clk_mode;
    logic [TIME_W-1:0] base_us;
    logic [TIME_W-1:0] game_us;
    logic [TIME_W-1:0] slip_us;
    logic [CNT_W-1:0]  grant_left;
    logic [TIME_W-1:0] tick_sum;
    logic [TIME_W-1:0] per_ticks;
    logic [TIME_W-1:0] per_time;
    rsp_t              due_results[$];
    int unsigned       errors;

    function new();
      max_tick   = MAX_TICK_RST;
      debug_tick = DEBUG_TICK_RST;
      clk_mode   = MODE_REALTIME;
      base_us    = '0;
      game_us    = '0;
      slip_us    = '0;
      grant_left = '0;
      tick_sum   = '0;
      per_ticks  = '0;
      per_time   = '0;
      errors     = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] value);
      if (idx == REG_MAX_TICK) begin
        max_tick = value;
      end else begin
        debug_tick = value;
      end
    endfunction

    // Works out the interval for one tick and advances the clock state.
    function logic [CFG_W-1:0] issue_interval(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] target;
      logic [TIME_W-1:0] lag;
      logic [TIME_W-1:0] dt;
      if (clk_mode == MODE_TERMINATED) return '0;
      elapsed = now - base_us;
      target  = game_us + slip_us;
      // Real time behind the expected time counts as no lag.
      lag = (elapsed > target) ? elapsed - target : '0;
      if (clk_mode == MODE_REALTIME) begin
        if (lag > TIME_W'(max_tick)) begin
          slip_us = slip_us + (lag - TIME_W'(max_tick));
          lag     = TIME_W'(max_tick);
        end
        dt        = lag;
        tick_sum  = tick_sum + 1'b1;
        per_ticks = per_ticks + 1'b1;
      end else begin
        slip_us = slip_us + lag;
        if (grant_left != 0) begin
          dt         = TIME_W'(debug_tick);
          grant_left = grant_left - 1'b1;
          tick_sum   = tick_sum + 1'b1;
          per_ticks  = per_ticks + 1'b1;
        end else begin
          dt = '0;
        end
        // The deviation saturates at zero when the issued step exceeds it.
        slip_us = (dt > slip_us) ? '0 : slip_us - dt;
      end
      game_us  = game_us + dt;
      per_time = per_time + dt;
      return dt[CFG_W-1:0];
    endfunction

    // Notes an accepted request and queues the result it must produce.
    function void log_request(req_t r);
      rsp_t e;
      e = '0;
      case (r.req_type)
        REQ_TICK: begin
          e.interval_us = issue_interval(r.now_us);
        end
        REQ_START: begin
          if (r.cold_start) clk_mode = MODE_DEBUG;
          base_us = r.now_us;
          game_us = '0;
          slip_us = '0;
        end
        REQ_TO_REALTIME: begin
          if (clk_mode == MODE_REALTIME) begin
            e.ok = 1'b1;
          end else if (clk_mode == MODE_DEBUG && grant_left == 0) begin
            clk_mode = MODE_REALTIME;
            e.ok     = 1'b1;
          end
        end
        REQ_TO_DEBUG: begin
          if (clk_mode != MODE_TERMINATED) begin
            clk_mode = MODE_DEBUG;
            e.ok     = 1'b1;
          end
        end
        REQ_TERMINATE: begin
          clk_mode = MODE_TERMINATED;
        end
        REQ_GRANT: begin
          if (clk_mode == MODE_DEBUG && grant_left == 0) begin
            grant_left = r.tick_count;
            e.ok       = 1'b1;
          end
        end
        REQ_EXPORT: begin
          e.total_ticks  = tick_sum;
          e.realtime_us  = r.now_us - base_us;
          e.ingame_us    = game_us;
          e.deviation_us = slip_us;
          e.avg_tick_us  = (per_ticks != 0) ? per_time / per_ticks : '0;
          per_ticks      = '0;
          per_time       = '0;
        end
        default: begin
        end
      endcase
      e.mode = clk_mode;
      due_results.push_back(e);
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] want,
                                logic [TIME_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    // Checks one transferred result against the oldest queued one.
    function void match_result(rsp_t got);
      rsp_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("interval_us", TIME_W'(want.interval_us), TIME_W'(got.interval_us));
      compare_field("ok", TIME_W'(want.ok), TIME_W'(got.ok));
      compare_field("mode", TIME_W'(want.mode), TIME_W'(got.mode));
      compare_field("total_ticks", want.total_ticks, got.total_ticks);
      compare_field("ingame_us", want.ingame_us, got.ingame_us);
      compare_field("realtime_us", want.realtime_us, got.realtime_us);
      compare_field("deviation_us", want.deviation_us, got.deviation_us);
      compare_field("avg_tick_us", want.avg_tick_us, got.avg_tick_us);
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  sctc_req_if req_if ();
  sctc_rsp_if rsp_if ();

  tick_ledger  ledger = new();
  logic [TIME_W-1:0] now_cur = '0;
  int unsigned gap_rate   = 0;
  int unsigned stall_rate = 0;
  int unsigned stall_left = 0;
  int unsigned rate_choice[4] = '{0, 4, 10, 30};

  sim_clock_tick_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk_i = ~clk_i;

  // Result side: check each transfer, then stall ready in random bursts.
  always @(posedge clk_i) begin
    if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ledger.match_result(rsp_if.payload);
    if (stall_left != 0) begin
      stall_left--;
    end else if (stall_rate != 0 && $urandom_range(1, stall_rate) == 1) begin
      stall_left = $urandom_range(1, 19);
    end
    rsp_if.ready <= (stall_left == 0);
  end

  // Register write through the APB port: setup cycle, then access cycle.
  task automatic apb_write(reg_idx_e idx, logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    ledger.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offers one request, with an optional idle burst first, and waits for the transfer.
  task automatic send_request(req_t r);
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= r;
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    ledger.log_request(r);
  endtask

  task automatic send_fields(logic [2:0] kind, logic [TIME_W-1:0] now, logic cold,
                             logic [CNT_W-1:0] count);
    req_t r;
    r.req_type   = kind;
    r.now_us     = now;
    r.cold_start = cold;
    r.tick_count = count;
    send_request(r);
  endtask

  // Stops offering requests until every outstanding result has arrived.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly a plausible stream of requests on a moving time base, plus some noise.
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned jump;
    jump = $urandom_range(0, 99);
    if (jump < 90) begin
      now_cur = now_cur + $urandom_range(0, 25000);
    end else if (jump < 94) begin
      now_cur = now_cur - $urandom_range(0, 30000);
    end else if (jump < 97) begin
      now_cur = TIME_W'({$urandom, $urandom});
    end else begin
      now_cur = now_cur + $urandom;
    end
    r.now_us     = now_cur;
    r.cold_start = 1'($urandom_range(0, 1));
    r.tick_count = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      r.req_type = REQ_TICK;
    end else if (pick < 60) begin
      r.req_type = REQ_START;
    end else if (pick < 65) begin
      r.req_type = REQ_TO_REALTIME;
    end else if (pick < 72) begin
      r.req_type = REQ_TO_DEBUG;
    end else if (pick < 80) begin
      r.req_type = REQ_GRANT;
      r.tick_count = $urandom_range(0, 12);
    end else if (pick < 90) begin
      r.req_type = REQ_EXPORT;
    end else if (pick < 92) begin
      r.req_type = REQ_TERMINATE;
    end else if (pick < 94) begin
      r.req_type = REQ_UNUSED;
    end else begin
      // Noise: any code and a time unrelated to the running base.
      r.req_type = 3'($urandom_range(0, 7));
      r.now_us   = TIME_W'({$urandom, $urandom});
      // Keep accepted grants short so the debug mode can still be left.
      if (r.req_type == REQ_GRANT) r.tick_count[CNT_W-1:8] = '0;
    end
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] max_set[6];
    logic [CFG_W-1:0] dbg_set[6];
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    rsp_if.ready   = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    max_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd10000, 32'd0};
    dbg_set = '{32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'd10000, 32'd0};
    max_set[3] = $urandom;
    dbg_set[3] = $urandom;
    max_set[5] = $urandom_range(1, 50000);
    dbg_set[5] = $urandom_range(0, 50000);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sequence under the reset settings.
    apb_write(REG_MAX_TICK, 32'd10000);
    apb_write(REG_DEBUG_TICK, 32'd10000);
    gap_rate   = 4;
    stall_rate = 4;
    send_fields(REQ_EXPORT, '0, 1'b0, '0);
    send_fields(REQ_TICK, '0, 1'b0, '0);
    // Lag above the limit: clamp and book the rest as deviation.
    send_fields(REQ_TICK, 48'd25000, 1'b0, '0);
    // Real time behind the expected time.
    send_fields(REQ_TICK, 48'd5000, 1'b0, '0);
    send_fields(REQ_EXPORT, 48'd30000, 1'b0, '0);
    send_fields(REQ_UNUSED, TIME_MAX, 1'b1, '1);
    send_fields(REQ_GRANT, 48'd30000, 1'b0, 32'd5);
    send_fields(REQ_TO_DEBUG, 48'd30000, 1'b0, '0);
    send_fields(REQ_GRANT, 48'd30000, 1'b0, 32'd3);
    send_fields(REQ_GRANT, 48'd30000, 1'b0, 32'd2);
    send_fields(REQ_TO_REALTIME, 48'd30000, 1'b0, '0);
    send_fields(REQ_TICK, 48'd30000, 1'b0, '0);
    send_fields(REQ_TICK, 48'd30000, 1'b0, '0);
    // Debug step larger than the booked deviation.
    send_fields(REQ_TICK, 48'd30000, 1'b0, '0);
    send_fields(REQ_TICK, 48'd30000, 1'b0, '0);
    send_fields(REQ_GRANT, 48'd30000, 1'b0, '0);
    send_fields(REQ_TO_REALTIME, 48'd30000, 1'b0, '0);
    send_fields(REQ_TERMINATE, 48'd30000, 1'b0, '0);
    send_fields(REQ_TICK, 48'd90000, 1'b0, '0);
    send_fields(REQ_TO_DEBUG, 48'd90000, 1'b0, '0);
    send_fields(REQ_TO_REALTIME, 48'd90000, 1'b0, '0);
    send_fields(REQ_GRANT, 48'd90000, 1'b0, '1);
    send_fields(REQ_START, TIME_MAX, 1'b0, '0);
    // Cold start leaves the terminated mode; elapsed time then wraps.
    send_fields(REQ_START, 48'd1, 1'b1, '0);
    send_fields(REQ_EXPORT, '0, 1'b0, '0);

    // Random phases, each under its own register settings.
    for (int p = 0; p < 6; p++) begin
      drain_results();
      apb_write(REG_MAX_TICK, max_set[p]);
      apb_write(REG_DEBUG_TICK, dbg_set[p]);
      now_cur = ledger.base_us + ledger.game_us + ledger.slip_us;
      for (int i = 0; i < 200; i++) begin
        if (i % 50 == 0) begin
          if (p == 5) begin
            gap_rate   = 0;
            stall_rate = 0;
          end else begin
            gap_rate   = rate_choice[$urandom_range(0, 3)];
            stall_rate = rate_choice[$urandom_range(0, 3)];
          end
        end
        // Hold off mid-phase until the block has caught up.
        if (p == 2 && i == 100) drain_results();
        send_request(random_request());
      end
    end

    // Closing: the largest grant, which the debug mode never leaves again.
    send_fields(REQ_START, now_cur, 1'b1, '0);
    while (ledger.grant_left != 0) send_fields(REQ_TICK, now_cur, 1'b0, '0);
    send_fields(REQ_GRANT, now_cur, 1'b0, '1);
    send_fields(REQ_TICK, now_cur + 48'd100, 1'b0, '0);
    send_fields(REQ_TICK, now_cur + 48'd200, 1'b0, '0);
    send_fields(REQ_EXPORT, now_cur + 48'd300, 1'b0, '0);

    req_if.valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sim_clock_tick_controller.f
rtl/core/sctc_pkg.sv
rtl/core/sctc_if.sv
rtl/core/sctc_div.sv
rtl/core/sctc_dp.sv
rtl/core/sctc_ctrl.sv
rtl/core/sim_clock_tick_controller.sv
rtl/core/sctc_checker.sv
tb/sim_clock_tick_controller_tb.sv
